>>> hw/rtl/ogcs_pkg.sv
// ogcs_pkg: shared types, register codes and road color test for the grid scan
// used by ogcs_pos, occupancy_grid_collision_scan and the bench files; no dependencies
`timescale 1ns / 1ps

package ogcs_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_SIZE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IGNORE_ROW   = 3'd3;

  // register reset values
  localparam logic [10:0] FRAME_WIDTH_RST  = 11'd640;
  localparam logic [10:0] FRAME_HEIGHT_RST = 11'd360;
  localparam logic [6:0]  CELL_SIZE_RST    = 7'd20;
  localparam logic [10:0] IGNORE_ROW_RST   = 11'd13;

  // road class colors
  localparam logic [7:0] ROAD_C0 = 8'd128;
  localparam logic [7:0] ROAD_C1 = 8'd64;
  localparam logic [7:0] ROAD_C2 = 8'd128;
  localparam logic [7:0] VOID_C  = 8'd0;

  // output field widths
  localparam int COORD_W = 10;
  localparam int COUNT_W = 21;

  // per-pixel position flags from the raster counters
  typedef struct packed {
    logic cell_end;
    logic frame_done;
  } pos_flags_t;

  function automatic logic is_road(input logic [7:0] c0, input logic [7:0] c1,
                                   input logic [7:0] c2);
    is_road = (c0 == ROAD_C0 && c1 == ROAD_C1 && c2 == ROAD_C2) ||
              (c0 == VOID_C && c1 == VOID_C && c2 == VOID_C);
  endfunction

endpackage

>>> hw/rtl/ogcs_ram.sv
// ogcs_ram: generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module ogcs_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, holds when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/ogcs_pos.sv
// ogcs_pos: raster position counters, pixel and cell offsets, grid coordinates
// depends on ogcs_pkg
`timescale 1ns / 1ps

module ogcs_pos #(
  parameter int XW = 10,
  parameter int YW = 10,
  parameter int OW = 6
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                restart,
  input  logic                step,
  input  logic [XW:0]         w,
  input  logic [YW:0]         h,
  input  logic [OW:0]         cs,
  output logic [XW-1:0]       grid_col,
  output logic [YW-1:0]       grid_row,
  output ogcs_pkg::pos_flags_t flags
);

  import ogcs_pkg::*;

  logic [XW-1:0] pixel_x;
  logic [YW-1:0] pixel_y;
  logic [OW-1:0] offset_x;
  logic [OW-1:0] offset_y;

  logic row_end;
  logic col_end;
  logic oy_end;
  logic py_last;
  logic frame_done;

  // end-of-span tests for the current pixel
  always_comb begin
    row_end    = ({1'b0, pixel_x} + (XW+1)'(1)) >= w;
    col_end    = row_end || (({1'b0, offset_x} + (OW+1)'(1)) >= cs);
    oy_end     = ({1'b0, offset_y} + (OW+1)'(1)) >= cs;
    py_last    = ({1'b0, pixel_y} + (YW+1)'(1)) >= h;
    frame_done = row_end && py_last;
    flags.cell_end   = col_end && (py_last || oy_end);
    flags.frame_done = frame_done;
  end

  // raster advance
  always_ff @(posedge clk) begin
    if (rst || restart || (step && frame_done)) begin
      pixel_x  <= '0;
      pixel_y  <= '0;
      offset_x <= '0;
      offset_y <= '0;
      grid_col <= '0;
      grid_row <= '0;
    end else if (step) begin
      if (row_end) begin
        pixel_x  <= '0;
        offset_x <= '0;
        grid_col <= '0;
        pixel_y  <= pixel_y + YW'(1);
        if (oy_end) begin
          offset_y <= '0;
          grid_row <= grid_row + YW'(1);
        end else begin
          offset_y <= offset_y + OW'(1);
        end
      end else begin
        pixel_x <= pixel_x + XW'(1);
        if (col_end) begin
          offset_x <= '0;
          grid_col <= grid_col + XW'(1);
        end else begin
          offset_x <= offset_x + OW'(1);
        end
      end
    end
  end

endmodule

>>> hw/rtl/occupancy_grid_collision_scan.sv
// Occupancy grid collision scan: ORs non-road pixels over square cells, emits cell occupancy.
// Throughput one pixel per cycle while the output is not stalled; a pixel request is held in the
// stage 1 registers and its cell result goes to the output register when stage 1 fires. The column
// flag ram (one read, one write port) with forwarding of the previous write sets that rate.
// After reset and after every write to a defined register a clearing pass zeroes every address of
// the flag ram with in_ready low. Depends on ogcs_pkg, ogcs_ram, ogcs_pos.
`timescale 1ns / 1ps

module occupancy_grid_collision_scan #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int MAX_CELL   = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ogcs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ogcs_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [7:0]                         chan0,
  input  logic [7:0]                         chan1,
  input  logic [7:0]                         chan2,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [ogcs_pkg::COORD_W-1:0]       cell_row,
  output logic [ogcs_pkg::COORD_W-1:0]       cell_col,
  output logic                               occupied,
  output logic                               frame_end,
  output logic                               collision_found,
  output logic [ogcs_pkg::COORD_W-1:0]       first_row,
  output logic [ogcs_pkg::COORD_W-1:0]       first_col,
  output logic [ogcs_pkg::COUNT_W-1:0]       obstacle_count
);

  import ogcs_pkg::*;

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int OW = $clog2(MAX_CELL);

  // configuration registers
  logic [10:0] frame_width;
  logic [10:0] frame_height;
  logic [6:0]  cell_size;
  logic [10:0] ignore_row_start;

  logic cfg_write;
  logic cfg_hit;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  always_comb begin
    unique case (cfg_index) inside
      REG_FRAME_WIDTH, REG_FRAME_HEIGHT, REG_CELL_SIZE, REG_IGNORE_ROW: cfg_hit = cfg_write;
      default: cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width      <= FRAME_WIDTH_RST;
      frame_height     <= FRAME_HEIGHT_RST;
      cell_size        <= CELL_SIZE_RST;
      ignore_row_start <= IGNORE_ROW_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  frame_width      <= cfg_data;
        REG_FRAME_HEIGHT: frame_height     <= cfg_data;
        REG_CELL_SIZE:    cell_size        <= cfg_data[6:0];
        REG_IGNORE_ROW:   ignore_row_start <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamped frame geometry
  logic [31:0] w32, h32, cs32;
  logic [XW:0] w_eff;
  logic [YW:0] h_eff;
  logic [OW:0] cs_eff;

  always_comb begin
    if (frame_width == '0) w32 = 32'd1;
    else if (32'(frame_width) > 32'(MAX_WIDTH)) w32 = 32'(MAX_WIDTH);
    else w32 = 32'(frame_width);
    if (frame_height == '0) h32 = 32'd1;
    else if (32'(frame_height) > 32'(MAX_HEIGHT)) h32 = 32'(MAX_HEIGHT);
    else h32 = 32'(frame_height);
    if (cell_size == '0) cs32 = 32'd1;
    else if (32'(cell_size) > 32'(MAX_CELL)) cs32 = 32'(MAX_CELL);
    else cs32 = 32'(cell_size);
    w_eff  = w32[XW:0];
    h_eff  = h32[YW:0];
    cs_eff = cs32[OW:0];
  end

  // clearing pass over the flag ram
  logic          clearing;
  logic [XW-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + XW'(1);
      if (clr_addr == XW'(MAX_WIDTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // handshake and stage control
  logic s1_valid;
  logic s1_fire;
  logic accept;

  assign s1_fire  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !clearing && (!s1_valid || s1_fire);
  assign accept   = in_valid && in_ready;

  // raster position
  logic [XW-1:0] pos_col;
  logic [YW-1:0] pos_row;
  pos_flags_t    pos_flags;

  ogcs_pos #(
    .XW(XW),
    .YW(YW),
    .OW(OW)
  ) u_pos (
    .clk      (clk),
    .rst      (rst),
    .restart  (cfg_hit),
    .step     (accept),
    .w        (w_eff),
    .h        (h_eff),
    .cs       (cs_eff),
    .grid_col (pos_col),
    .grid_row (pos_row),
    .flags    (pos_flags)
  );

  // stage 1 request registers
  logic [XW-1:0] s1_col;
  logic [YW-1:0] s1_row;
  pos_flags_t    s1_flags;
  logic          s1_nonroad;
  logic          s1_fwd;
  logic          fwd_data;
  logic          fwd_hit;

  assign fwd_hit = accept && s1_fire && (pos_col == s1_col);

  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_col     <= pos_col;
      s1_row     <= pos_row;
      s1_flags   <= pos_flags;
      s1_nonroad <= !is_road(chan0, chan1, chan2);
      s1_fwd     <= fwd_hit;
    end
  end

  // column flag ram, read on accept, written back from stage 1 or zeroed while clearing
  logic          ram_we;
  logic [XW-1:0] ram_waddr;
  logic          ram_wdata;
  logic          ram_rdata;
  logic          flag_old;
  logic          occ;
  logic          flag_new;

  assign flag_old = s1_fwd ? fwd_data : ram_rdata;
  assign occ      = flag_old || s1_nonroad;
  assign flag_new = s1_flags.cell_end ? 1'b0 : occ;

  assign ram_we    = clearing || s1_fire;
  assign ram_waddr = clearing ? clr_addr : s1_col;
  assign ram_wdata = clearing ? 1'b0 : flag_new;

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      fwd_data <= flag_new;
    end
  end

  ogcs_ram #(
    .WIDTH(1),
    .DEPTH(MAX_WIDTH)
  ) u_flags (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (pos_col),
    .rdata (ram_rdata)
  );

  // collision summary
  logic          found;
  logic [YW-1:0] first_row_reg;
  logic [XW-1:0] first_col_reg;
  logic [COUNT_W-1:0] count_reg;

  logic          hit;
  logic          found_new;
  logic [YW-1:0] first_row_new;
  logic [XW-1:0] first_col_new;
  logic [COUNT_W-1:0] count_new;

  always_comb begin
    hit           = s1_flags.cell_end && occ && (32'(s1_row) < 32'(ignore_row_start));
    found_new     = found || hit;
    first_row_new = (hit && !found) ? s1_row : first_row_reg;
    first_col_new = (hit && !found) ? s1_col : first_col_reg;
    count_new     = count_reg + COUNT_W'(hit);
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_hit || (s1_fire && s1_flags.frame_done)) begin
      found         <= 1'b0;
      first_row_reg <= '0;
      first_col_reg <= '0;
      count_reg     <= '0;
    end else if (s1_fire) begin
      found         <= found_new;
      first_row_reg <= first_row_new;
      first_col_reg <= first_col_new;
      count_reg     <= count_new;
    end
  end

  // output register
  logic        out_load;
  logic [31:0] row32, col32, frow32, fcol32;

  assign out_load = s1_fire && s1_flags.cell_end;
  assign row32    = 32'(s1_row);
  assign col32    = 32'(s1_col);
  assign frow32   = 32'(first_row_new);
  assign fcol32   = 32'(first_col_new);

  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      cell_row        <= row32[COORD_W-1:0];
      cell_col        <= col32[COORD_W-1:0];
      occupied        <= occ;
      frame_end       <= s1_flags.frame_done;
      collision_found <= s1_flags.frame_done && found_new;
      first_row       <= s1_flags.frame_done ? frow32[COORD_W-1:0] : '0;
      first_col       <= s1_flags.frame_done ? fcol32[COORD_W-1:0] : '0;
      obstacle_count  <= s1_flags.frame_done ? count_new : '0;
    end
  end

  // checks
  a_no_accept_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !accept)
    else $error("pixel request taken during flag clearing");

  a_fwd_needs_stage: assert property (@(posedge clk) disable iff (rst)
    fwd_hit |=> s1_valid && s1_fwd)
    else $error("forwarded flag without a stage 1 request");

  a_summary_only_at_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && !frame_end |-> !collision_found && obstacle_count == '0)
    else $error("summary fields set on a non-final cell");

  a_cfg_restarts: assert property (@(posedge clk) disable iff (rst)
    cfg_hit |=> clearing && !s1_valid && !out_valid)
    else $error("register write did not restart the scan");

endmodule

>>> bench/ogcs_checker.sv
// ogcs_checker: watches the config, pixel and cell channels of the grid scan,
// predicts every cell report and compares it with what the block sends
// depends on ogcs_pkg for register codes, road colors and field widths
`timescale 1ns / 1ps

module ogcs_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [ogcs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ogcs_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic [7:0]                      chan0,
  input  logic [7:0]                      chan1,
  input  logic [7:0]                      chan2,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic [ogcs_pkg::COORD_W-1:0]    cell_row,
  input  logic [ogcs_pkg::COORD_W-1:0]    cell_col,
  input  logic                            occupied,
  input  logic                            frame_end,
  input  logic                            collision_found,
  input  logic [ogcs_pkg::COORD_W-1:0]    first_row,
  input  logic [ogcs_pkg::COORD_W-1:0]    first_col,
  input  logic [ogcs_pkg::COUNT_W-1:0]    obstacle_count,
  output int                              cell_errors,
  output int                              cells_pending
);
  import ogcs_pkg::*;

  localparam int GRID_MAX_W = 1024;
  localparam int GRID_MAX_H = 1024;
  localparam int CELL_MAX   = 64;
  localparam int SHOW_LIMIT = 10;

  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               occ;
    logic               last;
    logic               hit;
    logic [COORD_W-1:0] hit_row;
    logic [COORD_W-1:0] hit_col;
    logic [COUNT_W-1:0] hits;
  } cell_report_t;

  cell_report_t expected_cells[$];

  // shadow registers
  logic [10:0] width_cfg;
  logic [10:0] height_cfg;
  logic [6:0]  cell_cfg;
  logic [10:0] ignore_cfg;

  // raster position and per-column occupancy
  logic [9:0]  scan_x;
  logic [9:0]  scan_y;
  logic [5:0]  sub_x;
  logic [5:0]  sub_y;
  logic [9:0]  cell_x;
  logic [9:0]  cell_y;
  logic        col_occ [GRID_MAX_W];

  // collision summary of the current frame
  logic              have_hit;
  logic [9:0]        hit_row;
  logic [9:0]        hit_col;
  logic [COUNT_W-1:0] hit_count;

  function automatic int clamp_dim(input int v, input int hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic clear_scan();
    scan_x = '0;
    scan_y = '0;
    sub_x = '0;
    sub_y = '0;
    cell_x = '0;
    cell_y = '0;
    foreach (col_occ[i]) col_occ[i] = 1'b0;
    have_hit = 1'b0;
    hit_row = '0;
    hit_col = '0;
    hit_count = '0;
  endtask

  always @(posedge clk) begin : scan_model
    int w;
    int h;
    int cs;
    logic road;
    logic row_end;
    logic col_end;
    logic band_end;
    logic last_px;
    logic occ;
    logic known;
    cell_report_t want;
    cell_report_t got;

    if (rst) begin
      width_cfg = FRAME_WIDTH_RST;
      height_cfg = FRAME_HEIGHT_RST;
      cell_cfg = CELL_SIZE_RST;
      ignore_cfg = IGNORE_ROW_RST;
      clear_scan();
      expected_cells.delete();
    end else begin
      // compare a finished cell with the oldest prediction
      if (out_valid && out_ready) begin
        got = {cell_row, cell_col, occupied, frame_end, collision_found,
               first_row, first_col, obstacle_count};
        if (expected_cells.size() == 0) begin
          cell_errors++;
          if (cell_errors <= SHOW_LIMIT)
            $display("cell report row %0d col %0d with no pixel request pending",
                     cell_row, cell_col);
        end else begin
          want = expected_cells.pop_front();
          if (got !== want) begin
            cell_errors++;
            if (cell_errors <= SHOW_LIMIT) begin
              $display("cell mismatch exp: row %0d col %0d occ %b end %b hit %b at %0d,%0d n %0d",
                       want.row, want.col, want.occ, want.last, want.hit,
                       want.hit_row, want.hit_col, want.hits);
              $display("              got: row %0d col %0d occ %b end %b hit %b at %0d,%0d n %0d",
                       got.row, got.col, got.occ, got.last, got.hit,
                       got.hit_row, got.hit_col, got.hits);
            end
          end
        end
      end

      // register write, restarts the frame when it hits a real register
      if (cfg_valid && cfg_ready) begin
        known = 1'b1;
        case (cfg_index)
          REG_FRAME_WIDTH: begin
            width_cfg = cfg_data;
          end
          REG_FRAME_HEIGHT: begin
            height_cfg = cfg_data;
          end
          REG_CELL_SIZE: begin
            cell_cfg = cfg_data[6:0];
          end
          REG_IGNORE_ROW: begin
            ignore_cfg = cfg_data;
          end
          default: begin
            known = 1'b0;
          end
        endcase
        if (known) clear_scan();
      end

      // one pixel request
      if (in_valid && in_ready) begin
        w = clamp_dim(int'(width_cfg), GRID_MAX_W);
        h = clamp_dim(int'(height_cfg), GRID_MAX_H);
        cs = clamp_dim(int'(cell_cfg), CELL_MAX);
        road = (chan0 == ROAD_C0 && chan1 == ROAD_C1 && chan2 == ROAD_C2) ||
               (chan0 == VOID_C && chan1 == VOID_C && chan2 == VOID_C);
        row_end = int'(scan_x) + 1 >= w;
        col_end = row_end || int'(sub_x) + 1 >= cs;
        band_end = int'(scan_y) + 1 >= h || int'(sub_y) + 1 >= cs;
        last_px = row_end && int'(scan_y) + 1 >= h;

        if (!road) col_occ[cell_x] = 1'b1;

        // cell complete: emit it and fold it into the collision summary
        if (col_end && band_end) begin
          occ = col_occ[cell_x];
          col_occ[cell_x] = 1'b0;
          if (occ && {1'b0, cell_y} < ignore_cfg) begin
            if (!have_hit) begin
              have_hit = 1'b1;
              hit_row = cell_y;
              hit_col = cell_x;
            end
            hit_count = hit_count + 1'b1;
          end
          want.row = cell_y;
          want.col = cell_x;
          want.occ = occ;
          want.last = last_px;
          want.hit = last_px && have_hit;
          want.hit_row = last_px ? hit_row : '0;
          want.hit_col = last_px ? hit_col : '0;
          want.hits = last_px ? hit_count : '0;
          expected_cells = {expected_cells, want};
        end

        // advance the raster position
        if (last_px) begin
          clear_scan();
        end else if (row_end) begin
          scan_x = '0;
          sub_x = '0;
          cell_x = '0;
          scan_y = scan_y + 1'b1;
          if (int'(sub_y) + 1 >= cs) begin
            sub_y = '0;
            cell_y = cell_y + 1'b1;
          end else begin
            sub_y = sub_y + 1'b1;
          end
        end else begin
          scan_x = scan_x + 1'b1;
          if (col_end) begin
            sub_x = '0;
            cell_x = cell_x + 1'b1;
          end else begin
            sub_x = sub_x + 1'b1;
          end
        end
      end
    end
    cells_pending = expected_cells.size();
  end

endmodule

>>> bench/occupancy_grid_collision_scan_tb.sv
// occupancy_grid_collision_scan_tb: drives register writes and pixel frames into
// the grid scan with random stalls on both sides and gives the verdict
// depends on ogcs_pkg, occupancy_grid_collision_scan and ogcs_checker
`timescale 1ns / 1ps

module occupancy_grid_collision_scan_tb;
  import ogcs_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd5;

  localparam int RANDOM_ITEMS   = 250;
  localparam int QUIET_ITEMS    = 100;
  localparam int HOLD_CYCLES    = 400;
  localparam int SETTLE_CYCLES  = 8;
  localparam int END_CYCLES     = 20;
  localparam int WATCHDOG_LIMIT = 20000;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  logic [7:0]            chan0;
  logic [7:0]            chan1;
  logic [7:0]            chan2;
  logic                  out_valid;
  logic                  out_ready;
  logic [COORD_W-1:0]    cell_row;
  logic [COORD_W-1:0]    cell_col;
  logic                  occupied;
  logic                  frame_end;
  logic                  collision_found;
  logic [COORD_W-1:0]    first_row;
  logic [COORD_W-1:0]    first_col;
  logic [COUNT_W-1:0]    obstacle_count;

  int   cell_errors;
  int   cells_pending;
  int   stall_cycles;
  logic pixel_gaps_on;
  logic sink_stalls_on;
  logic hold_req;

  int occ_levels [5] = '{0, 3, 15, 50, 100};

  // corner colors: all ones, all zeros, both road colors and near misses
  logic [23:0] corner_pixels [16] = '{
    24'hFFFFFF, 24'h000000, 24'h804080, 24'h7FBF7F,
    24'h804080, 24'h000000, 24'hFFFFFF, 24'h804081, 24'h814080,
    24'h804180, 24'h000001, 24'h010000, 24'h7FBF7F,
    24'hFFFFFF, 24'h804080, 24'h00FF00
  };

  always #10 clk = ~clk;

  occupancy_grid_collision_scan dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .chan0(chan0), .chan1(chan1), .chan2(chan2),
    .out_valid(out_valid), .out_ready(out_ready),
    .cell_row(cell_row), .cell_col(cell_col), .occupied(occupied),
    .frame_end(frame_end), .collision_found(collision_found),
    .first_row(first_row), .first_col(first_col),
    .obstacle_count(obstacle_count)
  );

  ogcs_checker scan_check (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .chan0(chan0), .chan1(chan1), .chan2(chan2),
    .out_valid(out_valid), .out_ready(out_ready),
    .cell_row(cell_row), .cell_col(cell_col), .occupied(occupied),
    .frame_end(frame_end), .collision_found(collision_found),
    .first_row(first_row), .first_col(first_col),
    .obstacle_count(obstacle_count),
    .cell_errors(cell_errors), .cells_pending(cells_pending)
  );

  // road or non-road pixel, non-road split between noise and near misses
  function automatic logic [23:0] pick_pixel(input int occ_pct);
    logic [23:0] road_px;
    road_px = $urandom_range(0, 1) ? {ROAD_C0, ROAD_C1, ROAD_C2} : {3{VOID_C}};
    if ($urandom_range(0, 99) >= occ_pct) return road_px;
    if ($urandom_range(0, 1)) return road_px ^ (24'd1 << $urandom_range(0, 23));
    return 24'($urandom);
  endfunction

  // one pixel request, with an optional gap before it
  task automatic send_pixel(input logic [23:0] px);
    int gap;
    if (pixel_gaps_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 5);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    {chan0, chan1, chan2} <= px;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic run_pixels(input int n, input int occ_pct, input int pause_at);
    for (int i = 0; i < n; i++) begin
      // sender pause until every cell report is back
      if (i == pause_at) begin
        in_valid <= 1'b0;
        do @(negedge clk); while (cells_pending != 0);
      end
      send_pixel(pick_pixel(occ_pct));
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // drain all reports, then give the pipeline time to go quiet
  task automatic settle();
    in_valid <= 1'b0;
    do @(negedge clk); while (cells_pending != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_regs(input logic [10:0] w, input logic [10:0] h, input logic [10:0] cs,
                          input logic [10:0] ign, input logic [3:0] sel);
    settle();
    if (sel[0]) write_reg(REG_FRAME_WIDTH, w);
    if (sel[1]) write_reg(REG_FRAME_HEIGHT, h);
    if (sel[2]) write_reg(REG_CELL_SIZE, cs);
    if (sel[3]) write_reg(REG_IGNORE_ROW, ign);
    cfg_valid <= 1'b0;
  endtask

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if (rst || (cfg_valid && cfg_ready) || (in_valid && in_ready) ||
        (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // cell report sink: random stall bursts, one long hold on request
  initial begin : report_sink
    int stretch;
    out_ready = 1'b1;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        stretch = 1;
        while (stretch < HOLD_CYCLES) begin
          @(negedge clk);
          stretch++;
        end
        hold_req = 1'b0;
      end else if (sink_stalls_on && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(0, 4)) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int n;
    int frame_px;
    int random_items;
    logic [10:0] w;
    logic [10:0] h;
    logic [10:0] cs;
    logic [10:0] ign;
    logic [3:0] sel;

    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    chan0 = '0;
    chan1 = '0;
    chan2 = '0;
    pixel_gaps_on = 1'b1;
    sink_stalls_on = 1'b1;
    hold_req = 1'b0;
    random_items = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // corner colors at reset sizes, then single-pixel frames
    for (int i = 0; i < 4; i++) send_pixel(corner_pixels[i]);
    set_regs(11'd1, 11'd1, 11'd1, 11'd1, 4'b1111);
    for (int i = 4; i < 13; i++) send_pixel(corner_pixels[i]);
    set_regs(11'd0, 11'd0, 11'd0, 11'd0, 4'b1000);
    for (int i = 13; i < 16; i++) send_pixel(corner_pixels[i]);

    // partial cells; a write to a spare index must not restart the frame
    set_regs(11'd8, 11'd8, 11'd3, 11'd2, 4'b1111);
    run_pixels(30, 20, -1);
    settle();
    write_reg(REG_SPARE, 11'h7FF);
    cfg_valid <= 1'b0;
    run_pixels(98, 20, 50);

    // zero sizes fall back to one
    set_regs(11'd0, 11'd0, 11'd0, 11'd0, 4'b1111);
    run_pixels(6, 50, -1);

    // widest frame with saturated width, then the top of the tallest with zero cell size
    set_regs(11'd2047, 11'd1, 11'd1, 11'd1, 4'b1111);
    run_pixels(1024, 3, -1);
    set_regs(11'd1, 11'd2047, 11'd128, 11'd1024, 4'b1111);
    run_pixels(100, 2, -1);

    // largest cell, by masking and by saturation
    set_regs(11'd70, 11'd1, 11'h7C0, 11'd2047, 4'b1111);
    run_pixels(70, 1, -1);
    set_regs(11'd66, 11'd1, 11'h0C1, 11'd1, 4'b1111);
    run_pixels(66, 5, -1);

    // a write in the middle of a frame restarts it
    set_regs(11'd6, 11'd6, 11'd4, 11'd1, 4'b1111);
    run_pixels(20, 30, -1);
    set_regs(11'd6, 11'd6, 11'd4, 11'd2, 4'b1000);
    run_pixels(36, 30, -1);

    // sink holds off while pixels keep coming
    set_regs(11'd1, 11'd1, 11'd1, 11'd1, 4'b1111);
    hold_req = 1'b1;
    run_pixels(80, 50, -1);

    // random frame shapes, mostly whole frames, the tail without stalls
    while (random_items < RANDOM_ITEMS) begin
      if (random_items >= RANDOM_ITEMS - QUIET_ITEMS) begin
        pixel_gaps_on = 1'b0;
        sink_stalls_on = 1'b0;
      end
      w = 11'($urandom_range(1, 24));
      if ($urandom_range(0, 7) == 0) w = 11'($urandom_range(25, 120));
      if ($urandom_range(0, 15) == 0) w = 11'd0;
      h = 11'($urandom_range(1, 10));
      if ($urandom_range(0, 15) == 0) h = 11'd0;
      case ($urandom_range(0, 9))
        0: cs = 11'd0;
        1: cs = 11'($urandom_range(0, 2047));
        2: cs = 11'd64;
        default: cs = 11'($urandom_range(1, 6));
      endcase
      case ($urandom_range(0, 7))
        0: ign = 11'd0;
        1: ign = 11'($urandom_range(0, 2047));
        default: ign = 11'($urandom_range(0, 12));
      endcase
      sel = {($urandom_range(0, 3) != 0), ($urandom_range(0, 3) != 0), 2'b11};
      set_regs(w, h, cs, ign, sel);
      frame_px = ((w == 0) ? 1 : int'(w)) * ((h == 0) ? 1 : int'(h));
      n = frame_px * ((frame_px > 300) ? 1 : $urandom_range(1, 3));
      // broken frame, cut short and restarted by the next write
      if ($urandom_range(0, 7) == 0) n = $urandom_range(1, n);
      run_pixels(n, occ_levels[$urandom_range(0, 4)],
                 ($urandom_range(0, 9) == 0) ? n / 2 : -1);
      random_items += n;
    end

    in_valid <= 1'b0;
    do @(negedge clk); while (cells_pending != 0);
    repeat (END_CYCLES) @(negedge clk);
    if (cell_errors == 0 && cells_pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/ogcs_pkg.sv
hw/rtl/ogcs_ram.sv
hw/rtl/ogcs_pos.sv
hw/rtl/occupancy_grid_collision_scan.sv
bench/ogcs_checker.sv
bench/occupancy_grid_collision_scan_tb.sv
